@@ src/sgs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgs_pkg
// Shared constants, types and helper functions of the Savitzky-Golay smoother.
// ----------------------------------------------------------------------------
package sgs_pkg;

  localparam int MAX_HALF_WIDTH = 12;
  localparam int SAMPLE_BITS    = 20;
  localparam int COEF_FRAC_BITS = 18;

  localparam int LINE_DEPTH    = 2 * MAX_HALF_WIDTH + 1;
  localparam int POS_LIMIT     = 2 * MAX_HALF_WIDTH;
  localparam int POS_BITS      = $clog2(POS_LIMIT + 1);
  localparam int M_BITS        = $clog2(MAX_HALF_WIDTH + 1);
  localparam int ROM_IDX_BITS  = $clog2(MAX_HALF_WIDTH);
  localparam int LINE_IDX_BITS = $clog2(LINE_DEPTH);

  localparam int OUT_FRAC_BITS = 8;
  localparam int OUT_BITS      = 29;
  localparam int OUT_MAX       = 2 ** (OUT_BITS - 1) - 1;
  localparam int OUT_MIN       = -(2 ** (OUT_BITS - 1));

  localparam int TAP_BITS    = COEF_FRAC_BITS + 2;
  localparam int PROD_BITS   = SAMPLE_BITS + 1 + TAP_BITS;
  localparam int TREE_LEVELS = $clog2(LINE_DEPTH);
  localparam int TREE_LEAVES = 2 ** TREE_LEVELS;
  localparam int ACC_BITS    = PROD_BITS + TREE_LEVELS;
  localparam int RND_SHIFT   = COEF_FRAC_BITS - OUT_FRAC_BITS;
  localparam int Q_BITS      = ACC_BITS - RND_SHIFT + 1;

  localparam int IN_TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

  localparam int HW_REG_BITS   = 4;
  localparam int DEG_REG_BITS  = 3;
  localparam int CFG_DATA_BITS = 4;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [HW_REG_BITS-1:0]  HW_RESET  = 4'd2;
  localparam logic [DEG_REG_BITS-1:0] DEG_RESET = 3'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_HALF_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_POLY_DEGREE = 2'd1;

  typedef enum logic [1:0] {
    GRP_FLAT  = 2'd0,
    GRP_QUAD  = 2'd1,
    GRP_QUART = 2'd2
  } grp_t;

  typedef struct packed {
    logic [M_BITS-1:0] m;
    grp_t              grp;
  } rom_sel_t;

  typedef struct packed {
    logic                vld;
    logic                emit;
    logic                smooth;
    logic                last;
    logic [OUT_BITS-1:0] raw;
  } step_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] value;
    logic                smoothed;
    logic                last;
  } res_t;

  function automatic logic [M_BITS-1:0] eff_half(input logic [HW_REG_BITS-1:0] hw);
    logic [M_BITS-1:0] m;
    if (hw == '0) begin
      m = M_BITS'(1);
    end else if (32'(hw) > MAX_HALF_WIDTH) begin
      m = M_BITS'(MAX_HALF_WIDTH);
    end else begin
      m = M_BITS'(hw);
    end
    return m;
  endfunction

  function automatic grp_t grp_of(input logic [DEG_REG_BITS-1:0] deg);
    grp_t g;
    if (deg <= DEG_REG_BITS'(1)) begin
      g = GRP_FLAT;
    end else if (deg <= DEG_REG_BITS'(3)) begin
      g = GRP_QUAD;
    end else begin
      g = GRP_QUART;
    end
    return g;
  endfunction

  function automatic logic [OUT_BITS-1:0] raw_value(input logic [SAMPLE_BITS-1:0] s);
    logic [63:0] v;
    v = 64'(s) << OUT_FRAC_BITS;
    if (v > 64'(OUT_MAX)) begin
      v = 64'(OUT_MAX);
    end
    return v[OUT_BITS-1:0];
  endfunction

  function automatic logic [OUT_BITS-1:0] round_sat(input logic signed [ACC_BITS-1:0] acc);
    logic signed [Q_BITS-1:0] q;
    logic [OUT_BITS-1:0]      r;
    q = $signed({acc[ACC_BITS-1], acc[ACC_BITS-1:RND_SHIFT]})
      + $signed({{(Q_BITS-1){1'b0}}, acc[RND_SHIFT-1]});
    if (q > Q_BITS'(OUT_MAX)) begin
      r = OUT_BITS'(OUT_MAX);
    end else if (q < Q_BITS'(OUT_MIN)) begin
      r = OUT_BITS'(OUT_MIN);
    end else begin
      r = q[OUT_BITS-1:0];
    end
    return r;
  endfunction

endpackage

@@ src/sgs_tap_rom.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgs_tap_rom
// Constant tap table for all half widths and fit groups, registered per cell.
// ----------------------------------------------------------------------------
module sgs_tap_rom
  import sgs_pkg::*;
(
  input  logic                       clk,
  input  rom_sel_t                   sel,
  output logic signed [TAP_BITS-1:0] taps_r [LINE_DEPTH]
);

  logic signed [TAP_BITS-1:0] tab_flat  [MAX_HALF_WIDTH][LINE_DEPTH];
  logic signed [TAP_BITS-1:0] tab_quad  [MAX_HALF_WIDTH][LINE_DEPTH];
  logic signed [TAP_BITS-1:0] tab_quart [MAX_HALF_WIDTH][LINE_DEPTH];
  logic [ROM_IDX_BITS-1:0]    idx;

  for (genvar gm = 1; gm <= MAX_HALF_WIDTH; gm++) begin : g_m
    for (genvar gk = 0; gk < LINE_DEPTH; gk++) begin : g_k
      localparam longint M   = longint'(gm);
      localparam longint D   = (gk > gm) ? longint'(gk - gm) : longint'(gm - gk);
      localparam longint T   = D * D;
      localparam longint M2  = M * M;
      localparam bit     WIN = (gk <= 2 * gm);
      localparam longint FSC = longint'(1) << COEF_FRAC_BITS;
      // flat
      localparam longint DF  = 2 * M + 1;
      localparam longint QF  = (2 * FSC + DF) / (2 * DF);
      // quadratic
      localparam longint NQ0 = 3 * (3 * M * (M + 1) - 1 - 5 * T);
      localparam longint DQ0 = (4 * M2 - 1) * (2 * M + 3);
      localparam longint NQ  = (DQ0 < 0) ? -NQ0 : NQ0;
      localparam longint DQ  = (DQ0 < 0) ? -DQ0 : DQ0;
      localparam longint AQ  = ((NQ < 0) ? -NQ : NQ) << COEF_FRAC_BITS;
      localparam longint UQ  = (2 * AQ + DQ) / (2 * DQ);
      localparam longint SQ  = (NQ < 0) ? -UQ : UQ;
      // quartic
      localparam longint NR0 = 15 * ((15 * M2 * M2 + 30 * M2 * M - 35 * M2 - 50 * M + 12)
                             - 35 * (2 * M2 + 2 * M - 3) * T + 63 * T * T);
      localparam longint DR0 = 4 * (4 * M2 - 1) * (4 * M2 - 9) * (2 * M + 5);
      localparam longint NR  = (DR0 < 0) ? -NR0 : NR0;
      localparam longint DR  = (DR0 < 0) ? -DR0 : DR0;
      localparam longint AR  = ((NR < 0) ? -NR : NR) << COEF_FRAC_BITS;
      localparam longint UR  = (2 * AR + DR) / (2 * DR);
      localparam longint SR  = (NR < 0) ? -UR : UR;

      assign tab_flat[gm-1][gk]  = WIN ? TAP_BITS'(QF) : '0;
      assign tab_quad[gm-1][gk]  = WIN ? TAP_BITS'(SQ) : '0;
      assign tab_quart[gm-1][gk] = WIN ? TAP_BITS'(SR) : '0;
    end
  end

  assign idx = ROM_IDX_BITS'(sel.m - M_BITS'(1));

  always_ff @(posedge clk) begin
    for (int k = 0; k < LINE_DEPTH; k++) begin
      unique case (sel.grp)
        GRP_FLAT:  taps_r[k] <= tab_flat[idx][k];
        GRP_QUAD:  taps_r[k] <= tab_quad[idx][k];
        GRP_QUART: taps_r[k] <= tab_quart[idx][k];
        default:   taps_r[k] <= '0;
      endcase
    end
  end

endmodule

@@ src/sgs_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgs_cell
// One delay-line cell: holds a sample, passes it on, keeps its tap product.
// ----------------------------------------------------------------------------
module sgs_cell
  import sgs_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        shift,
  input  logic        [SAMPLE_BITS-1:0] sample_in,
  input  logic signed [TAP_BITS-1:0]  tap,
  output logic        [SAMPLE_BITS-1:0] sample_r,
  output logic signed [PROD_BITS-1:0] prod_r
);

  logic signed [SAMPLE_BITS:0]    smp_s;
  logic signed [PROD_BITS-1:0]    prod_nxt;

  assign smp_s    = {1'b0, sample_in};
  assign prod_nxt = PROD_BITS'(smp_s) * PROD_BITS'(tap);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
      prod_r   <= '0;
    end else if (shift) begin
      sample_r <= sample_in;
      prod_r   <= prod_nxt;
    end
  end

endmodule

@@ src/sgs_sum_tree.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgs_sum_tree
// Registered binary adder tree over the cell products, one level per stage.
// ----------------------------------------------------------------------------
module sgs_sum_tree
  import sgs_pkg::*;
(
  input  logic                        clk,
  input  logic                        adv,
  input  logic signed [PROD_BITS-1:0] prod [LINE_DEPTH],
  output logic signed [ACC_BITS-1:0]  sum
);

  logic signed [ACC_BITS-1:0] leaf   [TREE_LEAVES];
  logic signed [ACC_BITS-1:0] node_r [1:TREE_LEAVES-1];

  for (genvar gl = 0; gl < TREE_LEAVES; gl++) begin : g_leaf
    if (gl < LINE_DEPTH) begin : g_used
      assign leaf[gl] = ACC_BITS'(prod[gl]);
    end else begin : g_pad
      assign leaf[gl] = '0;
    end
  end

  for (genvar gi = 1; gi < TREE_LEAVES; gi++) begin : g_node
    if (2 * gi >= TREE_LEAVES) begin : g_bottom
      always_ff @(posedge clk) begin
        if (adv) begin
          node_r[gi] <= leaf[2*gi-TREE_LEAVES] + leaf[2*gi+1-TREE_LEAVES];
        end
      end
    end else begin : g_inner
      always_ff @(posedge clk) begin
        if (adv) begin
          node_r[gi] <= node_r[2*gi] + node_r[2*gi+1];
        end
      end
    end
  end

  assign sum = node_r[1];

endmodule

@@ src/savitzky_golay_smoother.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// savitzky_golay_smoother
// Streaming Savitzky-Golay smoother over frames of unsigned count samples.
//
// in_*  : one sample per word, in_tlast marks the last sample of a frame.
// out_* : one result per word, value in tdata, out_tuser set when smoothed,
//         out_tlast on the last result of a frame.
// cfg_* : register writes, index 0 half width, index 1 polynomial degree;
//         always ready, to be written between items.
// A result for sample n is formed when sample n+m enters; it passes through
// 1 product stage and 5 adder-tree levels into the output register. One
// sample per cycle is taken inside a frame while the skid register is empty;
// after in_tlast the block shifts the m held samples out, with in_tready low.
// Reset (synchronous, active low) clears the delay line, frame position,
// pipeline and output buffer and loads half width 2, degree 2.
// When the receiver stalls, the result waits in the output register, one more
// lands in a skid register, and then the whole pipeline and in_tready hold.
// ----------------------------------------------------------------------------
module savitzky_golay_smoother
  import sgs_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [IN_TDATA_BITS-1:0]   in_tdata,   // sample
  input  logic                       in_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [OUT_TDATA_BITS-1:0]  out_tdata,  // value
  output logic                       out_tuser,  // was_smoothed
  output logic                       out_tlast,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [CFG_DATA_BITS-1:0]   cfg_data
);

  logic [HW_REG_BITS-1:0]      hw_r, hw_nxt;
  logic [DEG_REG_BITS-1:0]     deg_r, deg_nxt;
  logic [M_BITS-1:0]           m;
  rom_sel_t                    rom_sel;
  logic signed [TAP_BITS-1:0]  taps [LINE_DEPTH];

  logic [POS_BITS-1:0]         pos_r, pos_nxt;
  logic [M_BITS-1:0]           flush_left_r, flush_left_nxt;
  logic [M_BITS-1:0]           flush_out_r, flush_out_nxt;
  logic                        flushing;
  logic                        adv;
  logic                        in_acc;
  logic                        step;
  logic [SAMPLE_BITS-1:0]      step_smp;
  logic [LINE_IDX_BITS-1:0]    raw_idx;

  logic        [SAMPLE_BITS-1:0] cell_smp  [LINE_DEPTH];
  logic signed [PROD_BITS-1:0]   cell_prod [LINE_DEPTH];
  logic signed [ACC_BITS-1:0]    sum;

  step_t                       stg_nxt;
  step_t                       stg_r [TREE_LEVELS+1];
  step_t                       stg_end;

  res_t                        res_new;
  logic                        push;
  res_t                        out_r, out_nxt, skid_r, skid_nxt;
  logic                        out_vld_r, out_vld_nxt, skid_vld_r, skid_vld_nxt;

  // configuration
  assign cfg_ready = 1'b1;

  always_comb begin
    hw_nxt  = hw_r;
    deg_nxt = deg_r;
    if (!rst_n) begin
      hw_nxt  = HW_RESET;
      deg_nxt = DEG_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_HALF_WIDTH) begin
        hw_nxt = cfg_data[HW_REG_BITS-1:0];
      end else if (cfg_index == CFG_POLY_DEGREE) begin
        deg_nxt = cfg_data[DEG_REG_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    hw_r  <= hw_nxt;
    deg_r <= deg_nxt;
  end

  assign m           = eff_half(hw_r);
  assign rom_sel.m   = eff_half(hw_nxt);
  assign rom_sel.grp = grp_of(deg_nxt);

  sgs_tap_rom u_tap_rom (
    .clk    (clk),
    .sel    (rom_sel),
    .taps_r (taps)
  );

  // step control
  assign adv       = !skid_vld_r;
  assign flushing  = (flush_left_r != '0);
  assign in_tready = adv && !flushing;
  assign in_acc    = in_tvalid && in_tready;
  assign step      = in_acc || (adv && flushing);
  assign step_smp  = in_acc ? in_tdata[SAMPLE_BITS-1:0] : '0;
  assign raw_idx   = LINE_IDX_BITS'(m) - LINE_IDX_BITS'(1);

  always_comb begin
    pos_nxt        = pos_r;
    flush_left_nxt = flush_left_r;
    flush_out_nxt  = flush_out_r;
    stg_nxt        = '0;
    stg_nxt.raw    = raw_value(cell_smp[raw_idx]);
    if (in_acc) begin
      stg_nxt.vld    = 1'b1;
      stg_nxt.emit   = (pos_r >= POS_BITS'(m));
      stg_nxt.smooth = (pos_r >= POS_BITS'({m, 1'b0}));
      if (in_tlast) begin
        pos_nxt        = '0;
        flush_left_nxt = m;
        flush_out_nxt  = (POS_BITS'(m) > pos_r) ? M_BITS'(pos_r + POS_BITS'(1)) : m;
      end else if (pos_r < POS_BITS'(POS_LIMIT)) begin
        pos_nxt = pos_r + POS_BITS'(1);
      end
    end else if (adv && flushing) begin
      stg_nxt.vld    = 1'b1;
      stg_nxt.emit   = (flush_left_r <= flush_out_r);
      stg_nxt.last   = (flush_left_r == M_BITS'(1));
      flush_left_nxt = flush_left_r - M_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      flush_left_r <= '0;
      flush_out_r  <= '0;
    end else begin
      pos_r        <= pos_nxt;
      flush_left_r <= flush_left_nxt;
      flush_out_r  <= flush_out_nxt;
    end
  end

  // delay line
  for (genvar gk = 0; gk < LINE_DEPTH; gk++) begin : g_cell
    if (gk == 0) begin : g_head
      sgs_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift     (step),
        .sample_in (step_smp),
        .tap       (taps[gk]),
        .sample_r  (cell_smp[gk]),
        .prod_r    (cell_prod[gk])
      );
    end else begin : g_body
      sgs_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift     (step),
        .sample_in (cell_smp[gk-1]),
        .tap       (taps[gk]),
        .sample_r  (cell_smp[gk]),
        .prod_r    (cell_prod[gk])
      );
    end
  end

  sgs_sum_tree u_sum_tree (
    .clk  (clk),
    .adv  (adv),
    .prod (cell_prod),
    .sum  (sum)
  );

  // step flags travel alongside the tree
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= TREE_LEVELS; i++) begin
        stg_r[i] <= '0;
      end
    end else if (adv) begin
      stg_r[0] <= stg_nxt;
      for (int i = 1; i <= TREE_LEVELS; i++) begin
        stg_r[i] <= stg_r[i-1];
      end
    end
  end

  assign stg_end = stg_r[TREE_LEVELS];

  // output register and skid
  assign res_new.value    = stg_end.smooth ? round_sat(sum) : stg_end.raw;
  assign res_new.smoothed = stg_end.smooth;
  assign res_new.last     = stg_end.last;
  assign push             = adv && stg_end.vld && stg_end.emit;

  always_comb begin
    out_nxt      = out_r;
    out_vld_nxt  = out_vld_r;
    skid_nxt     = skid_r;
    skid_vld_nxt = skid_vld_r;
    if (!out_vld_r || out_tready) begin
      if (skid_vld_r) begin
        out_nxt      = skid_r;
        out_vld_nxt  = 1'b1;
        skid_vld_nxt = 1'b0;
      end else begin
        out_nxt     = res_new;
        out_vld_nxt = push;
      end
    end else if (push) begin
      skid_nxt     = res_new;
      skid_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      out_vld_r  <= out_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TDATA_BITS'(out_r.value);
  assign out_tuser  = out_r.smoothed;
  assign out_tlast  = out_r.last;

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_vld_r |-> out_vld_r)
    else $error("skid word held while output register empty");

  a_last_is_raw: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_r.last) |-> !out_r.smoothed)
    else $error("frame end word marked as smoothed");

  a_flush_count: assert property (@(posedge clk) disable iff (!rst_n)
    flushing |-> ((flush_out_r != '0) && (flush_out_r <= m) && (flush_left_r <= m)))
    else $error("flush counters out of range");

  a_no_take_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (flush_left_r == $past(m)) && !in_tready)
    else $error("flush did not start after frame end");

endmodule
